// ===== src/assert_macros.svh =====
// assertion macros shared by the modular inverse rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MI_ASSERT(lbl, clk, rst_n, prop)
`define MI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/mi_pkg.sv =====
// types, microcode encoding and control program of the modular inverse
package mi_pkg;

  localparam int FIELD_W = 31;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [3:0]         pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_START,
    OP_DIV_WAIT,
    OP_MUL,
    OP_UPDATE,
    OP_FIXNEG,
    OP_FIXHI,
    OP_EMIT_OK,
    OP_EMIT_FAIL
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_N_ZERO,
    C_NR_ZERO,
    C_R_NOT_ONE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic can_emit;
    logic div_busy;
    logic n_zero;
    logic nr_zero;
    logic r_one;
  } flags_t;

  localparam pc_t PC_LOAD   = 4'd0;
  localparam pc_t PC_NCHK   = 4'd1;
  localparam pc_t PC_LOOP   = 4'd2;
  localparam pc_t PC_DSTART = 4'd3;
  localparam pc_t PC_DWAIT  = 4'd4;
  localparam pc_t PC_MUL    = 4'd5;
  localparam pc_t PC_UPD    = 4'd6;
  localparam pc_t PC_CHECK  = 4'd7;
  localparam pc_t PC_FIXNEG = 4'd8;
  localparam pc_t PC_FIXHI  = 4'd9;
  localparam pc_t PC_OK     = 4'd10;
  localparam pc_t PC_FAIL   = 4'd11;

  // control program: the op runs, then jump to target if cond holds
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      PC_LOAD:   w = '{op: OP_LOAD,      cond: C_NEVER,     target: PC_LOAD};
      PC_NCHK:   w = '{op: OP_NOP,       cond: C_N_ZERO,    target: PC_FAIL};
      PC_LOOP:   w = '{op: OP_NOP,       cond: C_NR_ZERO,   target: PC_CHECK};
      PC_DSTART: w = '{op: OP_DIV_START, cond: C_NEVER,     target: PC_LOAD};
      PC_DWAIT:  w = '{op: OP_DIV_WAIT,  cond: C_NEVER,     target: PC_LOAD};
      PC_MUL:    w = '{op: OP_MUL,       cond: C_NEVER,     target: PC_LOAD};
      PC_UPD:    w = '{op: OP_UPDATE,    cond: C_ALWAYS,    target: PC_LOOP};
      PC_CHECK:  w = '{op: OP_NOP,       cond: C_R_NOT_ONE, target: PC_FAIL};
      PC_FIXNEG: w = '{op: OP_FIXNEG,    cond: C_NEVER,     target: PC_LOAD};
      PC_FIXHI:  w = '{op: OP_FIXHI,     cond: C_NEVER,     target: PC_LOAD};
      PC_OK:     w = '{op: OP_EMIT_OK,   cond: C_ALWAYS,    target: PC_LOAD};
      PC_FAIL:   w = '{op: OP_EMIT_FAIL, cond: C_ALWAYS,    target: PC_LOAD};
      default:   w = '{op: OP_NOP,       cond: C_ALWAYS,    target: PC_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ===== src/mi_if.sv =====
// valid/ready channels for input and result items
interface mi_in_if;
  logic            valid;
  logic            ready;
  mi_pkg::field_t  value;
  mi_pkg::field_t  modulus;
  modport source (output valid, value, modulus, input ready);
  modport sink   (input valid, value, modulus, output ready);
endinterface

interface mi_out_if;
  logic            valid;
  logic            ready;
  mi_pkg::field_t  inverse;
  logic            found;
  modport source (output valid, inverse, found, input ready);
  modport sink   (input valid, inverse, found, output ready);
endinterface

// ===== src/mi_div.sv =====
// restoring divider, one quotient bit per cycle
`include "assert_macros.svh"
module mi_div #(
  parameter int OW = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [OW-1:0] dividend,
  input  logic [OW-1:0] divisor,
  output logic          busy,
  output logic [OW-1:0] quo,
  output logic [OW-1:0] rem
);
  localparam int CNT_W = $clog2(OW + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OW-1:0]    quo_r, quo_nxt;
  logic [OW-1:0]    rem_r, rem_nxt;
  logic [OW-1:0]    div_r;
  logic [OW:0]      partial;
  logic [OW:0]      diff;
  logic             ge;

  assign partial = {rem_r, quo_r[OW-1]};
  assign ge      = partial >= {1'b0, div_r};
  assign diff    = partial - {1'b0, div_r};

  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CNT_W'(OW);
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      quo_nxt = {quo_r[OW-2:0], ge};
      rem_nxt = ge ? diff[OW-1:0] : partial[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign busy = cnt_r != '0;
  assign quo  = quo_r;
  assign rem  = rem_r;

  `MI_ASSERT(a_div_rem_lt, clk, rst_n, $fell(busy) |-> (rem_r < div_r))
  `MI_ASSERT(a_div_start_idle, clk, rst_n, start |-> !busy)
endmodule

// ===== src/mi_seq.sv =====
// microcode sequencer: step counter, control rom and jump logic
`include "assert_macros.svh"
module mi_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  mi_pkg::flags_t  flags_i,
  output mi_pkg::ucode_t  ctl_o
);
  import mi_pkg::*;

  pc_t  pc_r, pc_nxt;
  logic hold;
  logic taken;

  assign ctl_o = ucode_rom(pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    case (ctl_o.op)
      OP_LOAD:      hold = !flags_i.in_valid;
      OP_DIV_WAIT:  hold = flags_i.div_busy;
      OP_EMIT_OK:   hold = !flags_i.can_emit;
      OP_EMIT_FAIL: hold = !flags_i.can_emit;
      default:      hold = 1'b0;
    endcase
    case (ctl_o.cond)
      C_ALWAYS:    taken = 1'b1;
      C_N_ZERO:    taken = flags_i.n_zero;
      C_NR_ZERO:   taken = flags_i.nr_zero;
      C_R_NOT_ONE: taken = !flags_i.r_one;
      default:     taken = 1'b0;
    endcase
    if (hold) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = ctl_o.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  `MI_ASSERT_NEXT(a_seq_load, clk, rst_n, ctl_o.op == OP_LOAD && flags_i.in_valid, pc_r == PC_NCHK)
endmodule

// ===== src/mi_dp.sv =====
// euclid datapath: remainders, coefficients, multiplier and result register
`include "assert_macros.svh"
module mi_dp #(
  parameter int WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mi_pkg::ucode_t  ctl,
  output mi_pkg::flags_t  flags,
  mi_in_if.sink           in_ch,
  mi_out_if.source        out_ch
);
  import mi_pkg::*;

  localparam int OW = (WIDTH - 1 < FIELD_W) ? WIDTH - 1 : FIELD_W;
  localparam int CW = OW + 1;

  logic [OW-1:0]        n_r, r_r, nr_r;
  logic signed [CW-1:0] t_r, nt_r;
  logic signed [CW:0]   prod_r;
  logic signed [OW+CW:0] prod_full;
  logic signed [CW:0]   t_diff;
  logic signed [CW-1:0] n_s;
  logic                 out_valid_r;
  field_t               out_inv_r;
  logic                 out_found_r;
  logic                 div_start;
  logic                 div_busy;
  logic [OW-1:0]        quo, rem;
  logic                 can_emit;
  logic                 emit;

  mi_div #(.OW(OW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (r_r),
    .divisor  (nr_r),
    .busy     (div_busy),
    .quo      (quo),
    .rem      (rem)
  );

  assign div_start = ctl.op == OP_DIV_START;
  assign prod_full = $signed({1'b0, quo}) * nt_r;
  assign t_diff    = {t_r[CW-1], t_r} - prod_r;
  assign n_s       = $signed({1'b0, n_r});
  assign can_emit  = !out_valid_r || out_ch.ready;
  assign emit      = can_emit && (ctl.op == OP_EMIT_OK || ctl.op == OP_EMIT_FAIL);

  assign in_ch.ready   = ctl.op == OP_LOAD;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.inverse = out_inv_r;
  assign out_ch.found  = out_found_r;

  assign flags = '{
    in_valid: in_ch.valid,
    can_emit: can_emit,
    div_busy: div_busy,
    n_zero:   n_r == '0,
    nr_zero:  nr_r == '0,
    r_one:    r_r == OW'(1)
  };

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        if (in_ch.valid) begin
          n_r  <= in_ch.modulus[OW-1:0];
          r_r  <= in_ch.modulus[OW-1:0];
          nr_r <= in_ch.value[OW-1:0];
          t_r  <= '0;
          nt_r <= CW'(1);
        end
      end
      OP_MUL: begin
        prod_r <= prod_full[CW:0];
      end
      OP_UPDATE: begin
        t_r  <= nt_r;
        nt_r <= t_diff[CW-1:0];
        r_r  <= nr_r;
        nr_r <= rem;
      end
      OP_FIXNEG: begin
        if (t_r[CW-1]) begin
          t_r <= t_r + n_s;
        end
      end
      OP_FIXHI: begin
        if (t_r >= n_s) begin
          t_r <= t_r - n_s;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_found_r <= ctl.op == OP_EMIT_OK;
      out_inv_r   <= (ctl.op == OP_EMIT_OK) ? FIELD_W'(t_r[OW-1:0]) : '0;
    end
  end

  `MI_ASSERT(a_dp_div_nonzero, clk, rst_n, (ctl.op == OP_DIV_START) |-> (nr_r != '0))
  `MI_ASSERT(a_dp_inv_range, clk, rst_n, (ctl.op == OP_EMIT_OK) |-> (!t_r[CW-1] && t_r < n_s))
endmodule

// ===== src/modular_inverse_top.sv =====
// modular inverse by extended euclid, microcoded over a shared divider
// each euclid step runs a divide, a multiply and an update; OW = min(WIDTH-1, 31)
// a restoring divider with one quotient bit per step; the sequencer waits while it is busy
// one item at a time; the result register frees the input while a result waits
// reset: synchronous active-low rst_n clears step counter, divider count, output valid
module modular_inverse_top #(
  parameter int WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  mi_in_if.sink     in_ch,
  mi_out_if.source  out_ch
);
  import mi_pkg::*;

  ucode_t ctl;
  flags_t flags;

  mi_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  mi_dp #(.WIDTH(WIDTH)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .flags  (flags),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );
endmodule

// ===== tb/tb.sv =====
// testbench for modular_inverse_top: directed and random operands against an extended euclid predictor
`timescale 1ns / 100ps

module tb;
  import mi_pkg::*;

  localparam int WIDTH        = 32;
  localparam int NUM_RANDOM   = 380;
  localparam int QUIET_ITEMS  = 60;
  localparam int DRAIN_AT     = 150;
  localparam int STALL_LIMIT  = 12000;
  localparam int SETTLE_CYCLES = 200;
  localparam field_t FIELD_MAX = '1;

  typedef struct packed {
    field_t inverse;
    logic   found;
  } inv_result_t;

  class inverse_scoreboard;
    inv_result_t expected_inverses[$];
    int          mismatches;
    int          operands_seen;
    int          found_seen;
    int          none_seen;

    function new();
      mismatches    = 0;
      operands_seen = 0;
      found_seen    = 0;
      none_seen     = 0;
    endfunction

    function inv_result_t predict_inverse(field_t value, field_t modulus);
      longint unsigned opmask;
      longint          a, b, r, nr, t, nt, q, tmp;
      inv_result_t     res;
      opmask = (64'd1 << ((WIDTH > 64) ? 63 : WIDTH - 1)) - 64'd1;
      a = longint'(64'(value) & opmask);
      b = longint'(64'(modulus) & opmask);
      res = '{inverse: '0, found: 1'b0};
      if (b != 0) begin
        r  = b;
        nr = a;
        t  = 0;
        nt = 1;
        while (nr != 0) begin
          q   = r / nr;
          tmp = t - q * nt;
          t   = nt;
          nt  = tmp;
          tmp = r - q * nr;
          r   = nr;
          nr  = tmp;
        end
        if (r == 1) begin
          tmp = t % b;
          if (tmp < 0) begin
            tmp = tmp + b;
          end
          res.inverse = field_t'(tmp);
          res.found   = 1'b1;
        end
      end
      return res;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    function void note_operands(field_t value, field_t modulus);
      expected_inverses.push_back(predict_inverse(value, modulus));
      operands_seen++;
    endfunction

    task check_inverse(field_t inverse, logic found);
      inv_result_t exp_res;
      if (expected_inverses.size() == 0) begin
        report_mismatch($sformatf("unexpected result inverse=%0d found=%0b", inverse, found));
      end else begin
        exp_res = expected_inverses.pop_front();
        if (found) found_seen++;
        else none_seen++;
        if (found !== exp_res.found) begin
          report_mismatch($sformatf("found=%0b, expected %0b", found, exp_res.found));
        end
        if (inverse !== exp_res.inverse) begin
          report_mismatch($sformatf("inverse=%0d, expected %0d", inverse, exp_res.inverse));
        end
      end
    endtask

    function int pending();
      return expected_inverses.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   idling_on = 1'b1;
  int   stall_count = 0;
  inverse_scoreboard inv_sb = new();

  mi_in_if  in_ch();
  mi_out_if out_ch();

  modular_inverse_top #(.WIDTH(WIDTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        inv_sb.note_operands(in_ch.value, in_ch.modulus);
      end
      if (out_ch.valid && out_ch.ready) begin
        inv_sb.check_inverse(out_ch.inverse, out_ch.found);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
        if (stall_count >= STALL_LIMIT) begin
          $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (idling_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  task send_operands(field_t value, field_t modulus);
    in_ch.valid   <= 1'b1;
    in_ch.value   <= value;
    in_ch.modulus <= modulus;
    do @(posedge clk); while (!in_ch.ready);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task send_random_operands();
    field_t value, modulus, g;
    int     kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        value   = field_t'($urandom);
        modulus = field_t'($urandom_range(1, 32'h7FFF_FFFF));
      end
      4, 5: begin
        modulus = field_t'($urandom_range(1, 1000));
        value   = field_t'($urandom_range(0, 2000));
      end
      6: begin
        g       = field_t'($urandom_range(2, 1000));
        modulus = g * field_t'($urandom_range(1, 100000));
        value   = g * field_t'($urandom_range(0, 100000));
      end
      7: begin
        modulus = field_t'($urandom_range(1, 65535));
        value   = field_t'($urandom_range(32'(modulus), 32'h7FFF_FFFF));
      end
      8: begin
        modulus = FIELD_MAX;
        value   = field_t'($urandom);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: modulus = '0;
          1: modulus = field_t'(1);
          2: modulus = field_t'(2);
          default: modulus = FIELD_MAX;
        endcase
        case ($urandom_range(0, 2))
          0: value = '0;
          1: value = FIELD_MAX;
          default: value = field_t'($urandom);
        endcase
      end
    endcase
    send_operands(value, modulus);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.value   <= '0;
    in_ch.modulus <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // modulus one
    send_operands('0, field_t'(1));
    send_operands(FIELD_MAX, field_t'(1));
    send_operands(field_t'(1), field_t'(1));
    // zero value
    send_operands('0, field_t'(7));
    send_operands('0, FIELD_MAX);
    // modulus zero
    send_operands(field_t'(5), '0);
    send_operands('0, '0);
    send_operands(FIELD_MAX, '0);
    // value at or above the modulus
    send_operands(field_t'(10), field_t'(7));
    send_operands(FIELD_MAX, FIELD_MAX);
    send_operands(FIELD_MAX, field_t'(2));
    send_operands(FIELD_MAX, FIELD_MAX - field_t'(1));
    // no inverse
    send_operands(field_t'(6), field_t'(9));
    send_operands(field_t'(32'h4000_0000), field_t'(32'h4000_0000 >> 3));
    // ordinary and extreme
    send_operands(field_t'(3), field_t'(7));
    send_operands(field_t'(1), FIELD_MAX);
    send_operands(field_t'(2), FIELD_MAX);
    send_operands(FIELD_MAX - field_t'(1), FIELD_MAX);
    send_operands(field_t'(1), field_t'(2));
    send_operands(field_t'(3), field_t'(32'h4000_0000));
    // consecutive fibonacci numbers for the longest step chain
    send_operands(field_t'(1134903170), field_t'(1836311903));
    send_operands(field_t'(1836311903), field_t'(1134903170));

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == DRAIN_AT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (inv_sb.pending() > 0) @(posedge clk);
      end
      if (i == NUM_RANDOM - QUIET_ITEMS) begin
        idling_on = 1'b0;
      end
      send_random_operands();
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (inv_sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d operand pairs: %0d with an inverse, %0d without",
             inv_sb.operands_seen, inv_sb.found_seen, inv_sb.none_seen);
    $display("includes modulus zero and one, zero values, shared factors and full-width operands");
    if (inv_sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/mi_pkg.sv
src/mi_if.sv
src/mi_div.sv
src/mi_seq.sv
src/mi_dp.sv
src/modular_inverse_top.sv
tb/tb.sv
